// ----- rtl/core/mbrtu_pkg.sv -----
`default_nettype none

package mbrtu_pkg;

  localparam int BUF_DEPTH = 32;
  localparam int IDX_W     = $clog2(BUF_DEPTH);
  localparam int LEN_W     = $clog2(BUF_DEPTH + 1);

  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam logic REG_NODE_ADDRESS = 1'b0;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_RECV    = 2'd1;
  localparam logic [1:0] PH_TIMEOUT = 2'd2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FN_READ_HOLDING = 8'h03;
  localparam logic [7:0] REG_BYTE        = 8'h01;
  localparam logic [7:0] CNT_BYTE        = 8'h01;
  localparam logic [7:0] ERR_BYTE        = 8'hEE;
  localparam logic [7:0] TAIL_BYTE       = 8'h00;

  localparam int HDR_ADDR_1 = 1;
  localparam int HDR_ADDR_2 = 2;
  localparam int HDR_ADDR_4 = 4;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/modbus_rtu_slave_frame_handler_top.sv -----
`default_nettype none

// Modbus RTU slave frame handler. A byte request (opcode 0) is written to
// the frame store while it has room. A tick request (opcode 1) ends the
// frame: the first tick after the last byte marks the timeout, the next one
// processes the frame. Processing walks the frame store (separate read and
// write ports), one stored byte per cycle unless the output register is held:
// one read launch, four header reads (bytes 0, 1, 2 and 4), then the echo of
// frame_length bytes with the CRC-16 folded in as they pass, then 0xEE on a
// CRC error or the five-byte reply on a match. A frame whose address does
// not match ends after the first header read; a held output register
// stalls the output. in_ready is high only while no frame is being
// processed. The store is read as zeros until an entry has been written
// since reset.

module modbus_rtu_slave_frame_handler_top (
  input  wire logic                            clk,
  input  wire logic                            rst,

  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            opcode,
  input  wire logic [7:0]                      rx_byte,
  input  wire logic [7:0]                      humidity,

  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [7:0]                           tx_byte,
  output logic                                 last_of_run,

  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mbrtu_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [mbrtu_pkg::PDATA_W-1:0]   pwdata,
  output logic [mbrtu_pkg::PDATA_W-1:0]        prdata,
  output logic                                 pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HDR   = 3'd1;
  localparam logic [2:0] S_ECHO  = 3'd2;
  localparam logic [2:0] S_ERR   = 3'd3;
  localparam logic [2:0] S_REPLY = 3'd4;

  localparam int IDX_W = mbrtu_pkg::IDX_W;
  localparam int LEN_W = mbrtu_pkg::LEN_W;

  // config
  logic [7:0] node_address;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_address <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == mbrtu_pkg::REG_NODE_ADDRESS) begin
      node_address <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == mbrtu_pkg::REG_NODE_ADDRESS) begin
      prdata = {{(mbrtu_pkg::PDATA_W-8){1'b0}}, node_address};
    end
  end

  // frame store
  logic [7:0]           mem [mbrtu_pkg::BUF_DEPTH];
  logic [mbrtu_pkg::BUF_DEPTH-1:0] mem_vld;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [7:0]           mem_wdata;
  logic                 mem_re;
  logic [IDX_W-1:0]     mem_raddr;
  logic [7:0]           rd_raw;
  logic                 rd_vld;
  logic [7:0]           rd_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_raw <= mem[mem_raddr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (mem_we) begin
        mem_vld[mem_waddr] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld <= mem_vld[mem_raddr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_raw : 8'h00;

  // control
  logic [2:0]       state, state_next;
  logic [1:0]       phase, phase_next;
  logic [LEN_W-1:0] len, len_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [1:0]       hdr, hdr_next;
  logic [2:0]       rep, rep_next;
  logic [15:0]      crc, crc_next;
  logic [7:0]       hum, hum_next;
  logic [7:0]       b0, b0_next;
  logic [7:0]       b1, b1_next;
  logic [7:0]       b2, b2_next;
  logic [7:0]       b4, b4_next;

  logic             out_free;
  logic             out_load;
  logic [7:0]       out_byte;
  logic             out_last;
  logic [15:0]      crc_upd;
  logic [LEN_W-1:0] wr_pos;
  logic             reply_match;

  assign in_ready    = (state == S_IDLE);
  assign out_free    = !out_valid || out_ready;
  assign crc_upd     = mbrtu_pkg::crc16_byte(crc, rd_data);
  assign wr_pos      = (phase == mbrtu_pkg::PH_IDLE) ? '0 : len;
  assign reply_match = (b1 == mbrtu_pkg::FN_READ_HOLDING) && (b2 == mbrtu_pkg::REG_BYTE) &&
                       (b4 == mbrtu_pkg::CNT_BYTE);

  always_comb begin
    state_next = state;
    phase_next = phase;
    len_next   = len;
    idx_next   = idx;
    hdr_next   = hdr;
    rep_next   = rep;
    crc_next   = crc;
    hum_next   = hum;
    b0_next    = b0;
    b1_next    = b1;
    b2_next    = b2;
    b4_next    = b4;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    out_load   = 1'b0;
    out_byte   = '0;
    out_last   = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (opcode == mbrtu_pkg::OP_BYTE) begin
            phase_next = mbrtu_pkg::PH_RECV;
            len_next   = wr_pos;
            if (wr_pos < LEN_W'(mbrtu_pkg::BUF_DEPTH)) begin
              mem_we    = 1'b1;
              mem_waddr = wr_pos[IDX_W-1:0];
              mem_wdata = rx_byte;
              len_next  = wr_pos + LEN_W'(1);
            end
          end else begin
            unique case (phase)
              mbrtu_pkg::PH_RECV: begin
                phase_next = mbrtu_pkg::PH_TIMEOUT;
              end
              mbrtu_pkg::PH_TIMEOUT: begin
                phase_next = mbrtu_pkg::PH_IDLE;
                hum_next   = humidity;
                crc_next   = mbrtu_pkg::CRC_INIT;
                hdr_next   = '0;
                mem_re     = 1'b1;
                mem_raddr  = '0;
                state_next = S_HDR;
              end
              default: begin
                phase_next = mbrtu_pkg::PH_IDLE;
              end
            endcase
          end
        end
      end
      S_HDR: begin
        case (hdr)
          2'd0: begin
            if (rd_data != node_address) begin
              state_next = S_IDLE;
            end else begin
              b0_next   = rd_data;
              mem_re    = 1'b1;
              mem_raddr = IDX_W'(mbrtu_pkg::HDR_ADDR_1);
              hdr_next  = 2'd1;
            end
          end
          2'd1: begin
            b1_next   = rd_data;
            mem_re    = 1'b1;
            mem_raddr = IDX_W'(mbrtu_pkg::HDR_ADDR_2);
            hdr_next  = 2'd2;
          end
          2'd2: begin
            b2_next   = rd_data;
            mem_re    = 1'b1;
            mem_raddr = IDX_W'(mbrtu_pkg::HDR_ADDR_4);
            hdr_next  = 2'd3;
          end
          default: begin
            b4_next    = rd_data;
            mem_re     = 1'b1;
            mem_raddr  = '0;
            idx_next   = '0;
            state_next = S_ECHO;
          end
        endcase
      end
      S_ECHO: begin
        if (out_free) begin
          out_load = 1'b1;
          out_byte = rd_data;
          crc_next = crc_upd;
          if (LEN_W'(idx) == len - LEN_W'(1)) begin
            if (crc_upd != 16'h0000) begin
              state_next = S_ERR;
            end else if (reply_match) begin
              rep_next   = '0;
              state_next = S_REPLY;
            end else begin
              out_last   = 1'b1;
              state_next = S_IDLE;
            end
          end else begin
            mem_re    = 1'b1;
            mem_raddr = idx + IDX_W'(1);
            idx_next  = idx + IDX_W'(1);
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_byte   = mbrtu_pkg::ERR_BYTE;
          out_last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          out_load  = 1'b1;
          rep_next  = rep + 3'd1;
          mem_waddr = IDX_W'(rep);
          case (rep)
            3'd0: out_byte = b0;
            3'd1: out_byte = b1;
            3'd2: begin
              out_byte = mbrtu_pkg::REG_BYTE;
              mem_we   = 1'b1;
            end
            3'd3: begin
              out_byte = hum;
              mem_we   = 1'b1;
            end
            default: begin
              out_byte   = mbrtu_pkg::TAIL_BYTE;
              mem_we     = 1'b1;
              out_last   = 1'b1;
              state_next = S_IDLE;
            end
          endcase
          mem_wdata = out_byte;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= mbrtu_pkg::PH_IDLE;
      len       <= '0;
      idx       <= '0;
      hdr       <= '0;
      rep       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      len   <= len_next;
      idx   <= idx_next;
      hdr   <= hdr_next;
      rep   <= rep_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    crc <= crc_next;
    hum <= hum_next;
    b0  <= b0_next;
    b1  <= b1_next;
    b2  <= b2_next;
    b4  <= b4_next;
    if (out_load) begin
      tx_byte     <= out_byte;
      last_of_run <= out_last;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(mbrtu_pkg::BUF_DEPTH))
    else $error("frame length beyond store depth");

  a_we_when: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_IDLE || state == S_REPLY))
    else $error("store written outside byte intake or reply");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  a_proc_phase: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (phase == mbrtu_pkg::PH_IDLE))
    else $error("frame processed while phase not idle");

  a_echo_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_ECHO) |-> (len != '0))
    else $error("echo of empty frame");

endmodule

`default_nettype wire
